@@ rtl/core/mi3_pkg.sv @@
`timescale 1ns / 1ps
package mi3_pkg;

  localparam int ELEMENT_WIDTH_DEF = 24;
  localparam int FRACTION_BITS_DEF = 16;
  localparam int NUM_ELEM          = 9;
  localparam int PRE_STAGES        = 6;

  // cofactor g = a[i0]*a[i1] - a[i2]*a[i3], elements row-major
  localparam logic [3:0] COF_IDX [NUM_ELEM][4] = '{
    '{4'd4, 4'd8, 4'd5, 4'd7},
    '{4'd2, 4'd7, 4'd1, 4'd8},
    '{4'd1, 4'd5, 4'd2, 4'd4},
    '{4'd5, 4'd6, 4'd3, 4'd8},
    '{4'd0, 4'd8, 4'd2, 4'd6},
    '{4'd2, 4'd3, 4'd0, 4'd5},
    '{4'd3, 4'd7, 4'd4, 4'd6},
    '{4'd1, 4'd6, 4'd0, 4'd7},
    '{4'd0, 4'd4, 4'd1, 4'd3}
  };

  function automatic int max_int(input int x, input int y);
    return (x > y) ? x : y;
  endfunction

endpackage

@@ rtl/core/mi3_div_lane.sv @@
`timescale 1ns / 1ps
module mi3_div_lane #(
  parameter int QW = mi3_pkg::ELEMENT_WIDTH_DEF,
  parameter int DW = 3 * mi3_pkg::ELEMENT_WIDTH_DEF + 3,
  parameter int NW = 4 * mi3_pkg::ELEMENT_WIDTH_DEF + 3
) (
  input  logic          clk,
  input  logic [QW:0]   en,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] dmag,
  output logic [QW-1:0] quo,
  output logic          ovf
);

  logic [NW-1:0] rem_r [QW+1];
  logic [DW-1:0] d_r   [QW+1];
  logic [QW-1:0] q_r   [QW+1];
  logic          ovf_r [QW+1];
  logic [NW-1:0] dmag_ext;

  assign dmag_ext = NW'(dmag);

  // first stage: quotient at or beyond 2^QW flags overflow
  always_ff @(posedge clk) begin
    if (en[0]) begin
      rem_r[0] <= num;
      d_r[0]   <= dmag;
      q_r[0]   <= '0;
      ovf_r[0] <= (num >= (dmag_ext << QW));
    end
  end

  for (genvar j = 1; j <= QW; j++) begin : g_step
    logic [NW-1:0] dsh;
    logic          ge;
    logic [QW-1:0] q_nxt;
    always_comb begin
      dsh   = NW'(d_r[j-1]) << (QW - j);
      ge    = (rem_r[j-1] >= dsh);
      q_nxt = q_r[j-1];
      q_nxt[QW-j] = ge;
    end
    always_ff @(posedge clk) begin
      if (en[j]) begin
        rem_r[j] <= ge ? (rem_r[j-1] - dsh) : rem_r[j-1];
        d_r[j]   <= d_r[j-1];
        q_r[j]   <= q_nxt;
        ovf_r[j] <= ovf_r[j-1];
      end
    end
  end

  assign quo = q_r[QW];
  assign ovf = ovf_r[QW];

endmodule

@@ rtl/core/matrix_inverse_3x3.sv @@
`timescale 1ns / 1ps
// 3x3 matrix inverse by the adjugate, signed fixed point elements
// in channel: one word per matrix, nine elements row-major, first in the low bits
// out channel: one word per matrix, nine inverse elements then the determinant;
//   out_tuser carries the singular and saturated flags
// pipeline: six cofactor, determinant and division setup stages, ELEMENT_WIDTH + 1
//   long-division stages (one quotient bit each) and the output register
// throughput: one matrix per cycle while the receiver does not stall
// reset clears every stage valid bit; payload registers are not reset
// when the receiver stalls, stages holding no word keep filling, and
//   in_tready falls only once every stage holds a word; nothing is lost
//   or repeated
// a zero determinant gives singular high, an all-zero inverse and determinant
module matrix_inverse_3x3 #(
  parameter int ELEMENT_WIDTH = mi3_pkg::ELEMENT_WIDTH_DEF,
  parameter int FRACTION_BITS = mi3_pkg::FRACTION_BITS_DEF,
  localparam int IN_W  = ((9 * ELEMENT_WIDTH + 7) / 8) * 8,
  localparam int OUT_W = ((10 * ELEMENT_WIDTH + 7) / 8) * 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [IN_W-1:0]  in_tdata,   // a_r0_c0 .. a_r2_c2
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [OUT_W-1:0] out_tdata,  // inv_r0_c0 .. inv_r2_c2, det_value
  output logic [1:0]       out_tuser   // singular, saturated
);
  import mi3_pkg::*;

  localparam int W   = ELEMENT_WIDTH;
  localparam int CW  = 2 * W + 1;
  localparam int PMW = 3 * W + 1;
  localparam int DW  = 3 * W + 3;
  localparam int NW  = max_int(CW + 2 * FRACTION_BITS, DW + W);
  localparam int NS  = PRE_STAGES + W + 2;
  localparam int OS  = NS - 1;

  logic [NS-1:0] v_r;
  logic [NS-1:0] en;

  // stage enables: a stage loads when empty or when its successor moves
  always_comb begin
    en[OS] = !v_r[OS] || out_tready;
    for (int k = OS - 1; k >= 0; k--) begin
      en[k] = !v_r[k] || en[k+1];
    end
  end

  assign in_tready  = en[0];
  assign out_tvalid = v_r[OS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) begin
        v_r[0] <= in_tvalid;
      end
      for (int k = 1; k < NS; k++) begin
        if (en[k]) begin
          v_r[k] <= v_r[k-1];
        end
      end
    end
  end

  logic signed [W-1:0] a [NUM_ELEM];
  for (genvar g = 0; g < NUM_ELEM; g++) begin : g_in
    assign a[g] = in_tdata[g*W +: W];
  end

  // products for the cofactors
  logic signed [2*W-1:0] pa_r [NUM_ELEM];
  logic signed [2*W-1:0] pb_r [NUM_ELEM];
  logic signed [W-1:0]   r0_p0_r [3];
  always_ff @(posedge clk) begin
    if (en[0]) begin
      for (int g = 0; g < NUM_ELEM; g++) begin
        pa_r[g] <= a[COF_IDX[g][0]] * a[COF_IDX[g][1]];
        pb_r[g] <= a[COF_IDX[g][2]] * a[COF_IDX[g][3]];
      end
      for (int j = 0; j < 3; j++) begin
        r0_p0_r[j] <= a[j];
      end
    end
  end

  // cofactors
  logic signed [CW-1:0] cof_r [NUM_ELEM];
  logic signed [W-1:0]  r0_p1_r [3];
  always_ff @(posedge clk) begin
    if (en[1]) begin
      for (int g = 0; g < NUM_ELEM; g++) begin
        cof_r[g] <= CW'(pa_r[g]) - CW'(pb_r[g]);
      end
      r0_p1_r <= r0_p0_r;
    end
  end

  // magnitudes, split partial products of first row against its cofactors
  logic [CW-1:0]    cmag   [NUM_ELEM];
  logic [NUM_ELEM-1:0] csgn;
  logic [W-1:0]     emag   [3];
  logic [2:0]       esg;
  always_comb begin
    for (int g = 0; g < NUM_ELEM; g++) begin
      csgn[g] = cof_r[g][CW-1];
      cmag[g] = csgn[g] ? CW'(-cof_r[g]) : CW'(cof_r[g]);
    end
    for (int j = 0; j < 3; j++) begin
      esg[j]  = r0_p1_r[j][W-1];
      emag[j] = esg[j] ? W'(-r0_p1_r[j]) : W'(r0_p1_r[j]);
    end
  end

  logic [2*W-1:0]      ppl_r [3];
  logic [2*W:0]        pph_r [3];
  logic [2:0]          psg_r;
  logic [CW-1:0]       cmag_p2_r [NUM_ELEM];
  logic [NUM_ELEM-1:0] csgn_p2_r;
  always_ff @(posedge clk) begin
    if (en[2]) begin
      for (int j = 0; j < 3; j++) begin
        ppl_r[j] <= emag[j] * cmag[3*j][W-1:0];
        pph_r[j] <= emag[j] * cmag[3*j][CW-1:W];
        psg_r[j] <= esg[j] ^ csgn[3*j];
      end
      cmag_p2_r <= cmag;
      csgn_p2_r <= csgn;
    end
  end

  // signed determinant terms
  logic signed [DW-1:0] sp_r [3];
  logic [CW-1:0]        cmag_p3_r [NUM_ELEM];
  logic [NUM_ELEM-1:0]  csgn_p3_r;
  logic [PMW-1:0]       pm [3];
  always_comb begin
    for (int j = 0; j < 3; j++) begin
      pm[j] = PMW'({pph_r[j], {W{1'b0}}}) + PMW'(ppl_r[j]);
    end
  end
  always_ff @(posedge clk) begin
    if (en[3]) begin
      for (int j = 0; j < 3; j++) begin
        sp_r[j] <= psg_r[j] ? -$signed(DW'(pm[j])) : $signed(DW'(pm[j]));
      end
      cmag_p3_r <= cmag_p2_r;
      csgn_p3_r <= csgn_p2_r;
    end
  end

  // determinant
  logic signed [DW-1:0] det_r;
  logic [CW-1:0]        cmag_p4_r [NUM_ELEM];
  logic [NUM_ELEM-1:0]  csgn_p4_r;
  always_ff @(posedge clk) begin
    if (en[4]) begin
      det_r     <= sp_r[0] + sp_r[1] + sp_r[2];
      cmag_p4_r <= cmag_p3_r;
      csgn_p4_r <= csgn_p3_r;
    end
  end

  // division setup
  logic          dneg;
  logic [DW-1:0] dmag;
  assign dneg = det_r[DW-1];
  assign dmag = dneg ? DW'(-det_r) : DW'(det_r);

  logic [NW-1:0]       num_r [NUM_ELEM];
  logic [DW-1:0]       dmag_r;
  logic                dneg_r;
  logic                zero_r;
  logic [NUM_ELEM-1:0] neg_r;
  always_ff @(posedge clk) begin
    if (en[5]) begin
      for (int g = 0; g < NUM_ELEM; g++) begin
        num_r[g] <= NW'(cmag_p4_r[g]) << (2 * FRACTION_BITS);
      end
      dmag_r <= dmag;
      dneg_r <= dneg;
      zero_r <= (det_r == '0);
      neg_r  <= csgn_p4_r ^ {NUM_ELEM{dneg}};
    end
  end

  // long division lanes and the words that travel beside them
  logic [W-1:0]        quo [NUM_ELEM];
  logic [NUM_ELEM-1:0] ovf;
  for (genvar g = 0; g < NUM_ELEM; g++) begin : g_lane
    mi3_div_lane #(
      .QW (W),
      .DW (DW),
      .NW (NW)
    ) u_lane (
      .clk  (clk),
      .en   (en[PRE_STAGES +: W + 1]),
      .num  (num_r[g]),
      .dmag (dmag_r),
      .quo  (quo[g]),
      .ovf  (ovf[g])
    );
  end

  logic [DW-1:0]       sb_dmag_r [W+1];
  logic [W:0]          sb_dneg_r;
  logic [W:0]          sb_zero_r;
  logic [NUM_ELEM-1:0] sb_neg_r  [W+1];
  always_ff @(posedge clk) begin
    if (en[PRE_STAGES]) begin
      sb_dmag_r[0] <= dmag_r;
      sb_dneg_r[0] <= dneg_r;
      sb_zero_r[0] <= zero_r;
      sb_neg_r[0]  <= neg_r;
    end
    for (int j = 1; j <= W; j++) begin
      if (en[PRE_STAGES + j]) begin
        sb_dmag_r[j] <= sb_dmag_r[j-1];
        sb_dneg_r[j] <= sb_dneg_r[j-1];
        sb_zero_r[j] <= sb_zero_r[j-1];
        sb_neg_r[j]  <= sb_neg_r[j-1];
      end
    end
  end

  // clamp, sign and pack
  localparam logic [W-1:0] LIM_POS = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] LIM_NEG = {1'b1, {(W-1){1'b0}}};

  logic [OUT_W-1:0] out_data_nxt;
  logic [1:0]       out_user_nxt;
  logic [OUT_W-1:0] out_data_r;
  logic [1:0]       out_user_r;

  always_comb begin
    logic [W-1:0]  lim;
    logic [W-1:0]  mag;
    logic          over;
    logic          sat;
    logic [DW-1:0] dsh;
    out_data_nxt = '0;
    sat          = 1'b0;
    for (int k = 0; k < NUM_ELEM; k++) begin
      lim  = sb_neg_r[W][k] ? LIM_NEG : LIM_POS;
      over = ovf[k] || (quo[k] > lim);
      mag  = over ? lim : quo[k];
      sat  = sat | over;
      out_data_nxt[k*W +: W] = sb_neg_r[W][k] ? -mag : mag;
    end
    dsh  = sb_dmag_r[W] >> (2 * FRACTION_BITS);
    lim  = sb_dneg_r[W] ? LIM_NEG : LIM_POS;
    over = dsh > DW'(lim);
    mag  = over ? lim : W'(dsh);
    sat  = sat | over;
    out_data_nxt[NUM_ELEM*W +: W] = sb_dneg_r[W] ? -mag : mag;
    out_user_nxt = {sat, 1'b0};
    if (sb_zero_r[W]) begin
      out_data_nxt = '0;
      out_user_nxt = 2'b01;
    end
  end

  always_ff @(posedge clk) begin
    if (en[OS]) begin
      out_data_r <= out_data_nxt;
      out_user_r <= out_user_nxt;
    end
  end

  assign out_tdata = out_data_r;
  assign out_tuser = out_user_r;

endmodule

@@ bench/matrix_inverse_3x3_tb.sv @@
`timescale 1ns / 1ps
module matrix_inverse_3x3_tb;

  localparam int EW = 24;
  localparam int FB = 16;
  localparam int IN_W = 216;
  localparam int OUT_W = 240;
  localparam int N_RANDOM = 930;
  localparam int STALL_LIMIT = 5000;

  typedef logic signed [EW-1:0] elem_t;
  typedef struct packed {
    logic [1:0] flags;
    logic [OUT_W-1:0] data;
  } inverse_word_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_W-1:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_W-1:0] out_tdata;
  logic [1:0] out_tuser;

  logic [IN_W-1:0] matrices_pending[$];
  inverse_word_t inverses_expected[$];
  int errors = 0;
  int quiet_cycles = 0;
  int cycle_no = 0;
  bit stimulus_done = 1'b0;

  matrix_inverse_3x3 u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic logic [EW-1:0] clamp_elem(input logic signed [127:0] v, ref bit sat);
    logic signed [127:0] hi;
    logic signed [127:0] lo;
    hi = (128'sd1 <<< (EW - 1)) - 1;
    lo = -(128'sd1 <<< (EW - 1));
    if (v > hi) begin
      sat = 1'b1;
      return hi[EW-1:0];
    end
    if (v < lo) begin
      sat = 1'b1;
      return lo[EW-1:0];
    end
    return v[EW-1:0];
  endfunction

  function automatic inverse_word_t invert_matrix(input logic [IN_W-1:0] word);
    logic signed [63:0] a[9];
    logic signed [63:0] cof[9];
    logic signed [127:0] det;
    logic signed [127:0] dmag;
    logic signed [127:0] q;
    logic signed [127:0] num;
    inverse_word_t res;
    bit sat;
    sat = 1'b0;
    res = '0;
    for (int i = 0; i < 9; i++) a[i] = elem_t'(word[i*EW +: EW]);
    cof[0] = a[4] * a[8] - a[5] * a[7];
    cof[1] = a[2] * a[7] - a[1] * a[8];
    cof[2] = a[1] * a[5] - a[2] * a[4];
    cof[3] = a[5] * a[6] - a[3] * a[8];
    cof[4] = a[0] * a[8] - a[2] * a[6];
    cof[5] = a[2] * a[3] - a[0] * a[5];
    cof[6] = a[3] * a[7] - a[4] * a[6];
    cof[7] = a[1] * a[6] - a[0] * a[7];
    cof[8] = a[0] * a[4] - a[1] * a[3];
    det = 128'(a[0]) * cof[0] + 128'(a[1]) * cof[3] + 128'(a[2]) * cof[6];
    if (det == 0) begin
      res.flags[0] = 1'b1;
      return res;
    end
    dmag = (det < 0) ? -det : det;
    for (int i = 0; i < 9; i++) begin
      num = 128'(cof[i]) <<< (2 * FB);
      q = ((num < 0) ? -num : num) / dmag;
      if ((cof[i] < 0) != (det < 0)) q = -q;
      res.data[i*EW +: EW] = clamp_elem(q, sat);
    end
    q = dmag >>> (2 * FB);
    if (det < 0) q = -q;
    res.data[9*EW +: EW] = clamp_elem(q, sat);
    res.flags[1] = sat;
    return res;
  endfunction

  function automatic logic [EW-1:0] random_elem();
    case ($urandom_range(0, 9))
      0: return 24'h7fffff;
      1: return 24'h800000;
      2: return 24'h0;
      3: return EW'($urandom_range(0, 255));
      4: return EW'(-$urandom_range(0, 255));
      5: return 24'h010000;
      6, 7: return EW'($signed($urandom_range(0, 2 * 65536 * 4)) - 65536 * 4);
      default: return EW'($urandom);
    endcase
  endfunction

  function automatic logic [IN_W-1:0] pack_matrix(input logic [EW-1:0] e[9]);
    logic [IN_W-1:0] w;
    w = '0;
    for (int i = 0; i < 9; i++) w[i*EW +: EW] = e[i];
    return w;
  endfunction

  initial begin
    logic [EW-1:0] e[9];
    int pick;
    for (int i = 0; i < 9; i++) e[i] = '0;
    // identity, scaled, singular, all-max, all-min, tiny determinant, huge determinant
    e[0] = 24'h010000; e[4] = 24'h010000; e[8] = 24'h010000;
    matrices_pending.push_back(pack_matrix(e));
    e[0] = 24'hff0000; e[4] = 24'h020000; e[8] = 24'h008000;
    matrices_pending.push_back(pack_matrix(e));
    e[0] = 24'h000001; e[4] = 24'h000001; e[8] = 24'h000001;
    matrices_pending.push_back(pack_matrix(e));
    e[0] = 24'h7fffff; e[4] = 24'h7fffff; e[8] = 24'h7fffff;
    matrices_pending.push_back(pack_matrix(e));
    e[0] = 24'h800000; e[4] = 24'h800000; e[8] = 24'h800000;
    matrices_pending.push_back(pack_matrix(e));
    e[0] = 24'h800000; e[4] = 24'h7fffff; e[8] = 24'h800000;
    matrices_pending.push_back(pack_matrix(e));
    for (int i = 0; i < 9; i++) e[i] = 24'h7fffff;
    matrices_pending.push_back(pack_matrix(e));
    for (int i = 0; i < 9; i++) e[i] = 24'h800000;
    matrices_pending.push_back(pack_matrix(e));
    for (int i = 0; i < 9; i++) e[i] = '0;
    matrices_pending.push_back(pack_matrix(e));
    for (int i = 0; i < 9; i++) e[i] = 24'hffffff;
    matrices_pending.push_back(pack_matrix(e));
    for (int i = 0; i < 9; i++) e[i] = EW'(i + 1) << FB;
    matrices_pending.push_back(pack_matrix(e));
    e[8] = 24'h0a0000;
    matrices_pending.push_back(pack_matrix(e));
    for (int i = 0; i < 9; i++) e[i] = (i % 4 == 0) ? 24'h7fffff : 24'h800000;
    matrices_pending.push_back(pack_matrix(e));
    for (int n = 0; n < N_RANDOM; n++) begin
      pick = $urandom_range(0, 9);
      for (int i = 0; i < 9; i++) e[i] = random_elem();
      if (pick == 0) begin
        // dependent rows give a zero determinant
        for (int i = 0; i < 3; i++) e[6 + i] = e[i];
      end else if (pick == 1) begin
        for (int i = 0; i < 9; i++) e[i] = (i % 4 == 0) ? random_elem() : '0;
      end
      matrices_pending.push_back(pack_matrix(e));
    end
    stimulus_done = 1'b1;
  end

  function automatic bit idle_now();
    if (cycle_no >= 300 && cycle_no < 700) return 1'b0;
    return $urandom_range(0, 99) < 33;
  endfunction

  always @(posedge clk) begin
    cycle_no <= cycle_no + 1;
    if (cycle_no == 2) rst_n <= 1'b1;
    if (rst_n) begin
      if (!in_tvalid || in_tready) begin
        if (matrices_pending.size() > 0 && !idle_now()) begin
          in_tvalid <= 1'b1;
          in_tdata <= matrices_pending.pop_front();
        end else begin
          in_tvalid <= 1'b0;
        end
      end
      out_tready <= !idle_now();
    end
  end

  always @(posedge clk) begin
    inverse_word_t want;
    if (rst_n) begin
      if (in_tvalid && in_tready) inverses_expected.push_back(invert_matrix(in_tdata));
      if (out_tvalid && out_tready) begin
        if (inverses_expected.size() == 0) begin
          $display("%0t unexpected word %h %b", $time, out_tdata, out_tuser);
          errors++;
        end else begin
          want = inverses_expected.pop_front();
          for (int i = 0; i < 10; i++) begin
            if (out_tdata[i*EW +: EW] !== want.data[i*EW +: EW]) begin
              $display("%0t field %0d expected %h actual %h", $time, i,
                       want.data[i*EW +: EW], out_tdata[i*EW +: EW]);
              errors++;
            end
          end
          if (out_tuser !== want.flags) begin
            $display("%0t flags expected %b actual %b", $time, want.flags, out_tuser);
            errors++;
          end
        end
      end
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    wait (stimulus_done);
    fork
      begin
        wait (matrices_pending.size() == 0 && !in_tvalid && inverses_expected.size() == 0);
        repeat (40) @(posedge clk);
        if (errors == 0 && inverses_expected.size() == 0) begin
          $display("== PASS ==");
        end else begin
          $display("== FAIL ==");
        end
        $finish;
      end
      begin
        wait (quiet_cycles >= STALL_LIMIT);
        $display("timeout");
        $display("== FAIL ==");
        $finish;
      end
    join
  end

endmodule

@@ files.f @@
rtl/core/mi3_pkg.sv
rtl/core/mi3_div_lane.sv
rtl/core/matrix_inverse_3x3.sv
bench/matrix_inverse_3x3_tb.sv
